### rtl/core/tnms_pkg.sv
// ----------------------------------------------------------------------------
// tnms_pkg
// Shared types and constants of the nearest transition search block.
// ----------------------------------------------------------------------------
package tnms_pkg;

    // operation codes, carried in the input tuser
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PRE_TOL = 2'd0;
    localparam logic [1:0] REG_PRO_TOL = 2'd1;
    localparam logic [1:0] REG_IN_USE  = 2'd2;

    localparam int MZ_W    = 32;
    localparam int TOL_W   = 24;
    localparam int CHG_W   = 4;
    localparam int SLOT_W  = 8;
    localparam int CNT_W   = 9;
    localparam int SQ_W    = 2 * TOL_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int S_DATA_W = 144;
    localparam int M_DATA_W = 64;
    localparam int CFG_W    = 24;

    // one library entry as stored in the table
    typedef struct packed {
        logic signed [CHG_W-1:0] charge;
        logic [MZ_W-1:0]         product;
        logic [MZ_W-1:0]         precursor;
    } t_entry;

    // query and limits seen by the scan datapath
    typedef struct packed {
        logic [MZ_W-1:0]         precursor;
        logic [MZ_W-1:0]         product;
        logic signed [CHG_W-1:0] polarity;
        logic [TOL_W-1:0]        pre_tol;
        logic [TOL_W-1:0]        pro_tol;
    } t_scan_query;

    // sequencer to datapath control
    typedef struct packed {
        logic              start;
        logic              issue;
        logic [SLOT_W-1:0] slot;
    } t_scan_ctl;

    // datapath to sequencer status and result
    typedef struct packed {
        logic              busy;
        logic              found;
        logic [SLOT_W-1:0] slot;
        logic [DIST_W-1:0] dist_sq;
    } t_scan_stat;

endpackage

### rtl/core/tnms_table.sv
// ----------------------------------------------------------------------------
// tnms_table
// Library table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tnms_table
    import tnms_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data
);

    t_entry r_mem [DEPTH];
    t_entry r_rd_data;

    // write one entry per load beat
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read: data follows the read enable in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/tnms_scan.sv
// ----------------------------------------------------------------------------
// tnms_scan
// Scan datapath: filter each entry, square the differences, keep the nearest.
// ----------------------------------------------------------------------------
module tnms_scan
    import tnms_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_scan_ctl   i_ctl,
    input  t_scan_query i_query,
    input  t_entry      i_rd_data,
    output t_scan_stat  o_stat
);

    // stage valids
    logic r_v1, r_v2, r_v3;
    logic [SLOT_W-1:0] r_slot1, r_slot2, r_slot3;

    // stage 2: filter result and differences
    logic              r_pass2;
    logic [TOL_W-1:0]  r_a2, r_b2;

    // stage 3: squares
    logic              r_pass3;
    logic [SQ_W-1:0]   r_sq_a3, r_sq_b3;

    // best so far
    logic              r_have;
    logic [SLOT_W-1:0] r_best_slot;
    logic [DIST_W-1:0] r_best_dist;

    logic [MZ_W-1:0]   a_full, b_full;
    logic              pass;
    logic [DIST_W-1:0] sum_sq;
    logic              better;

    // absolute differences and filter on the entry just read
    always_comb begin
        a_full = (i_rd_data.precursor >= i_query.precursor)
               ? i_rd_data.precursor - i_query.precursor
               : i_query.precursor - i_rd_data.precursor;
        b_full = (i_rd_data.product >= i_query.product)
               ? i_rd_data.product - i_query.product
               : i_query.product - i_rd_data.product;
        pass = (i_rd_data.precursor != '0)
            && (i_rd_data.charge == i_query.polarity)
            && (a_full <= MZ_W'(i_query.pre_tol))
            && (b_full <= MZ_W'(i_query.pro_tol));
    end

    // sum of squares against the best so far
    assign sum_sq = DIST_W'(r_sq_a3) + DIST_W'(r_sq_b3);
    assign better = r_pass3 && (!r_have || (sum_sq < r_best_dist));

    // advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_ctl.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r_slot1 <= i_ctl.slot;
        r_slot2 <= r_slot1;
        r_pass2 <= r_v1 && pass;
        r_a2    <= TOL_W'(a_full);
        r_b2    <= TOL_W'(b_full);
        r_slot3 <= r_slot2;
        r_pass3 <= r_v2 && r_pass2;
        r_sq_a3 <= r_a2 * r_a2;
        r_sq_b3 <= r_b2 * r_b2;
    end

    // keep the first nearest entry; clear at query start
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have      <= 1'b0;
            r_best_slot <= '0;
            r_best_dist <= '0;
        end else if (i_ctl.start) begin
            r_have      <= 1'b0;
            r_best_slot <= '0;
            r_best_dist <= '0;
        end else if (r_v3 && better) begin
            r_have      <= 1'b1;
            r_best_slot <= r_slot3;
            r_best_dist <= sum_sq;
        end
    end

    assign o_stat.busy    = r_v1 || r_v2 || r_v3;
    assign o_stat.found   = r_have;
    assign o_stat.slot    = r_best_slot;
    assign o_stat.dist_sq = r_best_dist;

endmodule

### rtl/core/transition_nearest_match_search.sv
// ----------------------------------------------------------------------------
// transition_nearest_match_search
// Nearest library entry search within precursor and product tolerances.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s side): tuser selects the beat kind, load or query.
//   A load beat writes one table slot and gives no result;
//   a slot beyond the table depth is dropped. A query beat scans slots
//   0 .. entries_in_use-1 (clamped to the table depth) and gives one
//   result beat on the m side: tuser is found, tdata the slot and the
//   squared distance of the first nearest match, all zero when none.
//   The table read port reads one entry per cycle while a query scans;
//   after a query beat s_tready stays low while the slots are read, the
//   filter, square and compare pipeline drains and the result waits for
//   the output register to be free. Once it is free, the result beat is
//   loaded into it as the block goes back to idle.
//   s_tready is high only while no query is running.
//   The result sits in an output register; a new beat may be accepted
//   while it waits. If the receiver stalls, the next query holds its
//   result until the register is free.
//   Configuration writes (i_cfg_wen) take effect at once; the user must
//   make them only while the block is idle; the block does not enforce
//   this. Reset is synchronous and clears control state and the registers
//   to their defaults; table contents stay undefined until loaded.
// ----------------------------------------------------------------------------
module transition_nearest_match_search
    import tnms_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration write port
    input  logic                i_cfg_wen,
    input  logic [1:0]          i_cfg_index,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    // input stream
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // entry_index, entry_precursor, entry_product, entry_charge,
    // query_precursor, query_product, query_polarity
    input  logic [S_DATA_W-1:0] i_s_tdata,
    // operation
    input  logic                i_s_tuser,
    // result stream
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // match_index, match_distance_sq, zero fill
    output logic [M_DATA_W-1:0] o_m_tdata,
    // found
    output logic                o_m_tuser
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_limit, n_limit;

    logic [TOL_W-1:0] r_pre_tol, r_pro_tol;
    logic [CNT_W-1:0] r_in_use;

    logic [MZ_W-1:0]         r_q_pre, r_q_pro;
    logic signed [CHG_W-1:0] r_q_pol;

    logic              r_m_valid;
    logic              r_m_found;
    logic [SLOT_W-1:0] r_m_slot;
    logic [DIST_W-1:0] r_m_dist;

    // input field split
    logic [SLOT_W-1:0]       in_index;
    t_entry                  in_entry;
    logic [MZ_W-1:0]         in_q_pre, in_q_pro;
    logic signed [CHG_W-1:0] in_q_pol;

    logic        s_accept;
    logic        is_load, is_query;
    logic        wr_en;
    logic [CNT_W-1:0] clamp_limit;
    logic        out_load;

    t_scan_ctl   scan_ctl;
    t_scan_query scan_query;
    t_scan_stat  scan_stat;
    t_entry      rd_data;

    assign in_index           = i_s_tdata[7:0];
    assign in_entry.precursor = i_s_tdata[39:8];
    assign in_entry.product   = i_s_tdata[71:40];
    assign in_entry.charge    = i_s_tdata[75:72];
    assign in_q_pre           = i_s_tdata[107:76];
    assign in_q_pro           = i_s_tdata[139:108];
    assign in_q_pol           = i_s_tdata[143:140];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign is_load    = s_accept && (i_s_tuser == OP_LOAD);
    assign is_query   = s_accept && (i_s_tuser == OP_QUERY);
    assign wr_en      = is_load && (32'(in_index) < TABLE_DEPTH);

    assign clamp_limit = (32'(r_in_use) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : r_in_use;
    assign out_load    = (r_state == S_DONE) && (!r_m_valid || i_m_tready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_tol <= TOL_W'(32768);
            r_pro_tol <= TOL_W'(32768);
            r_in_use  <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                REG_PRE_TOL: r_pre_tol <= i_cfg_wdata;
                REG_PRO_TOL: r_pro_tol <= i_cfg_wdata;
                REG_IN_USE:  r_in_use  <= i_cfg_wdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // capture the query
    always_ff @(posedge i_clk) begin
        if (is_query) begin
            r_q_pre <= in_q_pre;
            r_q_pro <= in_q_pro;
            r_q_pol <= in_q_pol;
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_limit = r_limit;
        case (r_state)
            S_IDLE: begin
                if (is_query) begin
                    n_cnt   = '0;
                    n_limit = clamp_limit;
                    n_state = (clamp_limit == '0) ? S_DRAIN : S_SCAN;
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CNT_W'(1);
                if (r_cnt == r_limit - CNT_W'(1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!scan_stat.busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_limit   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_limit <= n_limit;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_found <= scan_stat.found;
            r_m_slot  <= scan_stat.slot;
            r_m_dist  <= scan_stat.dist_sq;
        end
    end

    assign scan_ctl.start = is_query;
    assign scan_ctl.issue = (r_state == S_SCAN);
    assign scan_ctl.slot  = r_cnt[SLOT_W-1:0];

    assign scan_query.precursor = r_q_pre;
    assign scan_query.product   = r_q_pro;
    assign scan_query.polarity  = r_q_pol;
    assign scan_query.pre_tol   = r_pre_tol;
    assign scan_query.pro_tol   = r_pro_tol;

    tnms_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(in_index)),
        .i_wr_data (in_entry),
        .i_rd_en   (scan_ctl.issue),
        .i_rd_addr (AW'(r_cnt)),
        .o_rd_data (rd_data)
    );

    tnms_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_query   (scan_query),
        .i_rd_data (rd_data),
        .o_stat    (scan_stat)
    );

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_found;
    assign o_m_tdata  = {7'd0, r_m_dist, r_m_slot};

endmodule

### rtl/core/tnms_checker.sv
// ----------------------------------------------------------------------------
// tnms_checker
// Port-level checks of the nearest transition search block, bound to the top.
// ----------------------------------------------------------------------------
module tnms_checker
    import tnms_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_s_tvalid,
    input logic                o_s_tready,
    input logic                i_s_tuser,
    input logic                o_m_tvalid,
    input logic                i_m_tready,
    input logic [M_DATA_W-1:0] o_m_tdata,
    input logic                o_m_tuser
);

    // a stalled result beat stays valid
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result beat dropped while stalled");

    // a miss carries an all-zero payload
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata == '0))
        else $error("miss result with nonzero payload");

    // the block is busy right after a query beat
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && (i_s_tuser == OP_QUERY) |=> !o_s_tready)
        else $error("input ready during query scan");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind transition_nearest_match_search tnms_checker u_tnms_checker (.*);
